// ===== src/aes_block_encrypt_defines.svh =====
// Assertion helpers for the AES block encryptor.
`ifndef AES_BLOCK_ENCRYPT_DEFINES_SVH
`define AES_BLOCK_ENCRYPT_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AES_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) (!rst_n) |-> (prop)) else $error(msg);
`else
`define AES_ASSERT(label, clk, rst_n, prop, msg)
`define AES_ASSERT_RST(label, clk, rst_n, prop, msg)
`endif
`endif

// ===== src/aesbe_pkg.sv =====
package aesbe_pkg;
	localparam int RkDepth = 60;
	localparam int MaxRounds = 14;
	localparam int NumStages = MaxRounds + 1;

	typedef enum logic [2:0] {
		REG_MODE = 3'd0,
		REG_KEY0 = 3'd1,
		REG_KEY1 = 3'd2,
		REG_KEY2 = 3'd3,
		REG_KEY3 = 3'd4
	} reg_idx_t;

	typedef logic [127:0] block_t;

	typedef struct packed {
		logic       busy;
		logic [3:0] num_rounds;
	} key_status_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// SubBytes and ShiftRows; byte r of column c sits at bits 127-8*(4c+r).
	function automatic block_t sub_shift(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction
endpackage

// ===== src/aesbe_if.sv =====
interface aesbe_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_high;
	logic [63:0] data_low;
	modport source (output valid, output data_high, output data_low, input ready);
	modport sink (input valid, input data_high, input data_low, output ready);
endinterface

// ===== src/aesbe_key_expand.sv =====
// Expands the cipher key one word per cycle after every register write.
// Round keys are held in flip-flops so every round stage reads its own four words.
module aesbe_key_expand
	import aesbe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output logic [RkDepth*32-1:0] round_keys,
	output key_status_t         status
);
	logic [1:0]  mode_q;
	logic [63:0] key_q [4];
	logic [31:0] rk_q [RkDepth];
	logic [31:0] win_q [8];
	logic [5:0]  idx_q;
	logic [2:0]  phase_q;
	logic [7:0]  rcon_q;
	logic        busy_q;
	logic [1:0]  eff_mode;
	logic [3:0]  nk;
	logic [5:0]  total;
	logic [31:0] prev, t, nxt, wr_word;
	logic        cfg_hit;
	logic        exp_en;

	assign eff_mode = (mode_q == 2'd3) ? 2'd2 : mode_q;
	assign nk = 4'd4 + {1'b0, eff_mode, 1'b0};
	assign total = 6'd4 * (6'(nk) + 6'd7);
	assign cfg_hit = cfg_we && cfg_index <= 3'(REG_KEY3);
	assign exp_en = busy_q && !cfg_hit;
	// The window holds the last eight words written, newest first.
	assign prev = win_q[0];

	always_comb begin
		t = prev;
		if (phase_q == 3'd0) begin
			t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && phase_q == 3'd4) begin
			t = sub_word(prev);
		end
		nxt = win_q[3'(nk - 4'd1)] ^ t;
	end

	always_comb begin
		if (idx_q < 6'(nk)) begin
			wr_word = idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32];
		end else if (idx_q < total) begin
			wr_word = nxt;
		end else begin
			wr_word = 32'h0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 2'd0;
			for (int k = 0; k < 4; k++) key_q[k] <= 64'h0;
			busy_q  <= 1'b1;
			idx_q   <= 6'd0;
			phase_q <= 3'd0;
			rcon_q  <= 8'h01;
		end else if (cfg_hit) begin
			if (cfg_index == 3'(REG_MODE)) mode_q <= cfg_data[1:0];
			else key_q[cfg_index[1:0] - 2'd1] <= cfg_data;
			busy_q  <= 1'b1;
			idx_q   <= 6'd0;
			phase_q <= 3'd0;
			rcon_q  <= 8'h01;
		end else if (busy_q) begin
			if (idx_q == 6'(RkDepth - 1)) busy_q <= 1'b0;
			idx_q <= idx_q + 6'd1;
			if (idx_q >= 6'(nk)) begin
				phase_q <= (phase_q == 3'(nk - 4'd1)) ? 3'd0 : phase_q + 3'd1;
				if (phase_q == 3'd0) rcon_q <= xtime(rcon_q);
			end
		end
	end

	// Payload of the store: key words first, then expansion, zero past the end.
	always_ff @(posedge clk) begin
		if (exp_en) begin
			rk_q[idx_q] <= wr_word;
			win_q[0] <= wr_word;
			for (int k = 1; k < 8; k++) win_q[k] <= win_q[k - 1];
		end
	end

	always_comb begin
		for (int k = 0; k < RkDepth; k++) round_keys[32 * k +: 32] = rk_q[k];
	end
	assign status.busy = busy_q;
	assign status.num_rounds = nk + 4'd6;
endmodule

// ===== src/aesbe_round.sv =====
// One cipher round stage with registered output and stall hold.
module aesbe_round
	import aesbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  block_t      in_state,
	input  logic        do_round,
	input  logic        is_final,
	input  logic [127:0] round_key,
	output logic        out_valid,
	output block_t      out_state
);
	block_t ss, mixed, nxt;
	assign ss = sub_shift(in_state);
	assign mixed = mix_columns(ss);
	always_comb begin
		priority if (!do_round) nxt = in_state;
		else if (is_final) nxt = ss ^ round_key;
		else nxt = mixed ^ round_key;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) out_state <= nxt;
	end
endmodule

// ===== src/aes_block_encrypt.sv =====
// AES encryptor, fully unrolled: one item per cycle sustained, back to back, while the output
// is not stalled and no key expansion runs. A result passes the whitening register and 14
// round stages; shorter keys pass the unused stages unchanged.
// Each round stage is one SubBytes/ShiftRows/MixColumns/AddRoundKey layer; the final round skips MixColumns.
// Reset clears all valid bits; during the key expansion that then follows, and after
// every register write, no item is accepted.
module aes_block_encrypt
	import aesbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	aesbe_if.sink       plain,
	aesbe_if.source     cipher
);
`include "aes_block_encrypt_defines.svh"
	logic [RkDepth*32-1:0] rks;
	key_status_t ks;
	logic adv;
	logic   v_s [NumStages+1];
	block_t st_s [NumStages+1];
	logic   v_s0;
	block_t st_s0;

	aesbe_key_expand u_key (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.round_keys(rks), .status(ks)
	);

	// Whole pipeline advances together; holds when the output is full and stalled.
	assign adv = !v_s[NumStages] || cipher.ready;
	assign plain.ready = adv && !ks.busy;
	assign v_s0 = plain.valid && plain.ready;
	assign st_s0 = {plain.data_high, plain.data_low} ^
		{rks[31:0], rks[63:32], rks[95:64], rks[127:96]};

	assign v_s[0] = v_s0;
	assign st_s[0] = st_s0;

	// Initial key add is done combinationally above; the first stage only registers it.
	aesbe_round u_white (
		.clk, .arst_n, .adv,
		.in_valid(v_s[0]), .in_state(st_s[0]),
		.do_round(1'b0),
		.is_final(1'b0),
		.round_key(128'h0),
		.out_valid(v_s[1]), .out_state(st_s[1])
	);

	for (genvar r = 1; r <= MaxRounds; r++) begin : g_round
		logic [127:0] rk;
		always_comb begin
			for (int c = 0; c < 4; c++) begin
				rk[127 - 32 * c -: 32] = rks[32 * ((4 * r + c) % RkDepth) +: 32];
			end
		end
		aesbe_round u_round (
			.clk, .arst_n, .adv,
			.in_valid(v_s[r]), .in_state(st_s[r]),
			.do_round(4'(r) <= ks.num_rounds),
			.is_final(4'(r) == ks.num_rounds),
			.round_key(rk),
			.out_valid(v_s[r+1]), .out_state(st_s[r+1])
		);
	end

	assign cipher.valid = v_s[NumStages];
	assign cipher.data_high = st_s[NumStages][127:64];
	assign cipher.data_low = st_s[NumStages][63:0];

	`AES_ASSERT(a_no_accept_busy, clk, arst_n, ks.busy |-> !plain.ready, "accepted during expansion")
	`AES_ASSERT(a_hold_stall, clk, arst_n, (cipher.valid && !cipher.ready) |=> $stable(cipher.data_low), "output changed in stall")
	`AES_ASSERT(a_flow, clk, arst_n, (v_s[1] && adv) |=> v_s[2], "item lost in stage two")
	`AES_ASSERT_RST(a_rst_empty, clk, arst_n, !cipher.valid, "valid during reset")
endmodule

// ===== tb/sv/tb_aes_block_encrypt.sv =====
module tb_aes_block_encrypt
	import aesbe_pkg::*;
();

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	aesbe_if plain();
	aesbe_if cipher();

	aes_block_encrypt dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.plain(plain.sink),
		.cipher(cipher.source)
	);

	localparam int CycleLimit = 400000;

	// Key setting and round keys of the predictor.
	logic [1:0] key_mode;
	logic [63:0] key_words [4];
	logic [31:0] round_keys [RkDepth];
	int unsigned round_count;

	block_t cipher_queue [$];
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned stall_pct;

	function automatic logic [7:0] gf_double(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	task automatic expand_round_keys();
		int unsigned mode;
		int unsigned nk;
		int unsigned total;
		logic [7:0] rcon;
		logic [31:0] t;
		logic [63:0] kw;
		mode = (key_mode == 2'd3) ? 2 : key_mode;
		nk = 4 + 2 * mode;
		round_count = nk + 6;
		total = 4 * (round_count + 1);
		rcon = 8'h01;
		for (int i = 0; i < RkDepth; i++) round_keys[i] = '0;
		for (int i = 0; i < nk; i++) begin
			kw = key_words[i / 2];
			round_keys[i] = (i % 2) ? kw[31:0] : kw[63:32];
		end
		for (int i = nk; i < total && i < RkDepth; i++) begin
			t = round_keys[i - 1];
			if (i % nk == 0) begin
				t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
				rcon = gf_double(rcon);
			end else if (nk > 6 && i % nk == 4) begin
				t = sbox_word(t);
			end
			round_keys[i] = round_keys[i - nk] ^ t;
		end
	endtask

	function automatic block_t encrypt_block(input block_t pt);
		logic [7:0] st [16];
		logic [7:0] tmp [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [31:0] w;
		block_t ct;
		for (int i = 0; i < 16; i++) st[i] = pt[127 - 8 * i -: 8];
		for (int rnd = 0; rnd <= round_count; rnd++) begin
			if (rnd > 0) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						tmp[r + 4 * c] = SBOX[st[r + 4 * ((c + r) % 4)]];
				st = tmp;
				if (rnd < round_count) begin
					for (int c = 0; c < 4; c++) begin
						a0 = st[4 * c]; a1 = st[4 * c + 1];
						a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
						all = a0 ^ a1 ^ a2 ^ a3;
						st[4 * c] = a0 ^ all ^ gf_double(a0 ^ a1);
						st[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
						st[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
						st[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
					end
				end
			end
			for (int c = 0; c < 4; c++) begin
				w = round_keys[(4 * rnd + c) % RkDepth];
				st[4 * c] ^= w[31:24];
				st[4 * c + 1] ^= w[23:16];
				st[4 * c + 2] ^= w[15:8];
				st[4 * c + 3] ^= w[7:0];
			end
		end
		for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = st[i];
		return ct;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h, expected %h", what, got, want);
		error_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout");
			$display("aes_block_encrypt test failed");
			$finish;
		end
	end

	// Result side: random stalls, compare with the oldest expected block.
	always @(posedge clk or negedge arst_n) begin
		block_t want;
		if (!arst_n) begin
			cipher.ready <= 1'b0;
		end else begin
			if (cipher.valid && cipher.ready) begin
				if (cipher_queue.size() == 0) begin
					report_mismatch("unexpected item", cipher.data_high, '0);
				end else begin
					want = cipher_queue.pop_front();
					if (cipher.data_high !== want[127:64])
						report_mismatch("cipher_high", cipher.data_high, want[127:64]);
					if (cipher.data_low !== want[63:0])
						report_mismatch("cipher_low", cipher.data_low, want[63:0]);
				end
			end
			cipher.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic write_register(input reg_idx_t idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODE) key_mode = value[1:0];
		else key_words[idx - REG_KEY0] = value;
		expand_round_keys();
	endtask

	task automatic set_key(input logic [1:0] mode, input logic [63:0] k0,
			input logic [63:0] k1, input logic [63:0] k2, input logic [63:0] k3);
		write_register(REG_MODE, {62'd0, mode});
		write_register(REG_KEY0, k0);
		write_register(REG_KEY1, k1);
		write_register(REG_KEY2, k2);
		write_register(REG_KEY3, k3);
	endtask

	// Waits until all results are back, then lets the pipeline drain.
	task automatic wait_drained();
		while (cipher_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Ready only changes at rising edges, so its value at the falling edge
	// is the one seen by the next rising edge.
	task automatic send_block(input block_t pt, input bit do_idle);
		while (do_idle && $urandom_range(99) < send_idle_pct) begin
			plain.valid <= 1'b0;
			@(posedge clk);
		end
		plain.valid <= 1'b1;
		plain.data_high <= pt[127:64];
		plain.data_low <= pt[63:0];
		@(negedge clk);
		while (!plain.ready) @(negedge clk);
		@(posedge clk);
		cipher_queue.push_back(encrypt_block(pt));
	endtask

	typedef struct {
		logic [1:0] mode;
		logic [63:0] k [4];
		block_t pt;
		block_t known;
		bit has_known;
	} vector_t;

	initial begin
		vector_t vectors [8];
		logic [1:0] mode;
		int unsigned phase_pct [4][2];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		plain.valid = 1'b0;
		plain.data_high = '0;
		plain.data_low = '0;
		cycle_count = 0;
		error_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		key_mode = '0;
		foreach (key_words[i]) key_words[i] = '0;
		expand_round_keys();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// FIPS-197 appendix C vectors, plus all-zero and all-one corners.
		vectors[0] = '{2'd0, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0},
			128'h00112233445566778899aabbccddeeff, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1};
		vectors[1] = '{2'd1, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h0},
			128'h00112233445566778899aabbccddeeff, 128'hdda97ca4864cdfe06eaf70a0ec0d7191, 1};
		vectors[2] = '{2'd2, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f},
			128'h00112233445566778899aabbccddeeff, 128'h8ea2b7ca516745bfeafc49904b496089, 1};
		vectors[3] = '{2'd0, '{64'h0, 64'h0, 64'h0, 64'h0}, '0,
			128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1};
		vectors[4] = '{2'd0, '{'1, '1, '1, '1}, '1, '0, 0};
		vectors[5] = '{2'd1, '{'1, '1, '1, '1}, '0, '0, 0};
		// Unused key size code runs as a 256-bit key.
		vectors[6] = '{2'd3, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f},
			128'h00112233445566778899aabbccddeeff, 128'h8ea2b7ca516745bfeafc49904b496089, 1};
		vectors[7] = '{2'd2, '{'1, '0, '1, '0}, '1, '0, 0};

		// Block right after reset uses the expansion of the all-zero key.
		send_block('0, 0);
		plain.valid <= 1'b0;
		wait_drained();
		if (encrypt_block('0) !== 128'h66e94bd4ef8a2c3b884cfa59ca342b2e)
			report_mismatch("zero key vector", 64'(encrypt_block('0) >> 64),
				64'h66e94bd4ef8a2c3b);

		foreach (vectors[i]) begin
			set_key(vectors[i].mode, vectors[i].k[0], vectors[i].k[1],
				vectors[i].k[2], vectors[i].k[3]);
			if (vectors[i].has_known && encrypt_block(vectors[i].pt) !== vectors[i].known)
				report_mismatch("known vector", 64'(encrypt_block(vectors[i].pt) >> 64),
					vectors[i].known[127:64]);
			send_block(vectors[i].pt, 0);
			send_block(~vectors[i].pt, 0);
			plain.valid <= 1'b0;
			wait_drained();
		end

		// Index beyond the register file is ignored by the block.
		cfg_we <= 1'b1;
		cfg_index <= 3'd7;
		cfg_data <= '1;
		@(posedge clk);
		cfg_we <= 1'b0;
		wait_drained();

		phase_pct = '{'{0, 0}, '{65, 0}, '{0, 65}, '{19, 19}};
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = phase_pct[ph % 4][0];
			stall_pct = phase_pct[ph % 4][1];
			mode = (ph % 4 == 3) ? 2'($urandom_range(3)) : 2'(ph % 3);
			set_key(mode, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
			for (int n = 0; n < 95; n++)
				send_block({$urandom, $urandom, $urandom, $urandom}, 1);
			plain.valid <= 1'b0;
			wait_drained();
		end

		if (error_count == 0) begin
			$display("aes_block_encrypt test passed");
		end else begin
			$display("aes_block_encrypt test failed");
		end
		$finish;
	end
endmodule
